>>> rtl/mts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants of the melody tone sequencer: opcode codes,
// field widths and the default note memory depth.
// ----------------------------------------------------------------------------
package mts_pkg;

    // Field widths of the input and result words.
    localparam int OPCODE_W = 2;
    localparam int START_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int PRIO_W   = 2;
    localparam int FREQ_W   = 16;
    localparam int DUR_W    = 16;
    localparam int NOTE_W   = FREQ_W + DUR_W;

    // Default depth of the note memory.
    localparam int NOTE_DEPTH_DEFAULT = 256;

    // Command codes carried by the opcode field.
    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_MELODY = 2'd1,
        OP_ALERT  = 2'd2,
        OP_TICK   = 2'd3
    } opcode_t;

endpackage : mts_pkg
`default_nettype wire

>>> rtl/melody_tone_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// melody_tone_sequencer
// Buzzer tone sequencer with a note memory, melody and alert runs, and
// melody save and resume around alerts.
// ----------------------------------------------------------------------------
// Usage:
// Each input word carries one command: write a note, start a melody, start
// an alert, or a one millisecond tick. Every accepted word yields exactly
// one result word with the buzzer frequency and the run status bits.
// A word is accepted when in_valid is high and in_stall is low; a result is
// taken when out_valid is high and out_stall is low.
// A word passes two stages: the first reads the note memory (or writes it
// for a note write), the second applies the note to the run state and
// loads the output register. No new word is taken while the first stage
// holds one, and that word's memory read waits until the previous word
// has updated the run state, since the note address of a tick follows
// from that state.
// Reset clears all run state and the output valid; the note memory holds
// no defined contents until written.
// When the receiver stalls, the result stays in the output register, the
// second stage holds its word, and in_stall rises once the first stage is
// occupied as well.
// ----------------------------------------------------------------------------
module melody_tone_sequencer
    import mts_pkg::*;
#(
    parameter int NOTE_DEPTH = NOTE_DEPTH_DEFAULT
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [OPCODE_W-1:0] opcode,
    input  wire logic [START_W-1:0]  start_address,
    input  wire logic [COUNT_W-1:0]  note_count,
    input  wire logic [PRIO_W-1:0]   alert_priority,
    input  wire logic [FREQ_W-1:0]   note_frequency,
    input  wire logic [DUR_W-1:0]    note_duration,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [FREQ_W-1:0]        tone_frequency,
    output logic                     sounding,
    output logic                     melody_mode,
    output logic                     resume_pending
);

    localparam int AW = $clog2(NOTE_DEPTH);
    // Width of a start address plus a step before wrapping.
    localparam int SUM_W = COUNT_W + 1;

    // Wrap an address sum into the note memory by constant compare and
    // subtract steps; eight steps cover every depth down to four.
    function automatic logic [AW-1:0] wrap_addr(input logic [SUM_W-1:0] v);
        logic [19:0] r;
        r = {{(20-SUM_W){1'b0}}, v};
        for (int k = 7; k >= 0; k--)
        begin
            if (r >= (20'(NOTE_DEPTH) << k))
            begin
                r = r - (20'(NOTE_DEPTH) << k);
            end
        end
        return r[AW-1:0];
    endfunction

    // Run state.
    logic                run_active_reg, run_active_next;
    logic                run_is_melody_reg, run_is_melody_next;
    logic [START_W-1:0]  run_start_reg, run_start_next;
    logic [COUNT_W-1:0]  run_count_reg, run_count_next;
    logic [COUNT_W-1:0]  run_step_reg, run_step_next;
    logic                saved_valid_reg, saved_valid_next;
    logic [START_W-1:0]  saved_start_reg, saved_start_next;
    logic [COUNT_W-1:0]  saved_count_reg, saved_count_next;
    logic [COUNT_W-1:0]  saved_step_reg, saved_step_next;
    logic [DUR_W-1:0]    saved_remaining_reg, saved_remaining_next;
    logic [DUR_W-1:0]    elapsed_reg, elapsed_next;
    logic [DUR_W-1:0]    duration_reg, duration_next;
    logic [PRIO_W-1:0]   held_prio_reg, held_prio_next;
    logic [FREQ_W-1:0]   tone_reg, tone_next;

    // First stage: memory access.
    logic                a_valid_reg;
    opcode_t             a_op_reg;
    logic [START_W-1:0]  a_start_reg;
    logic [COUNT_W-1:0]  a_count_reg;
    logic [PRIO_W-1:0]   a_prio_reg;
    logic [FREQ_W-1:0]   a_freq_reg;
    logic [DUR_W-1:0]    a_dur_reg;

    // Second stage: state update.
    logic                b_valid_reg;
    opcode_t             b_op_reg;
    logic [START_W-1:0]  b_start_reg;
    logic [COUNT_W-1:0]  b_count_reg;
    logic [PRIO_W-1:0]   b_prio_reg;

    // Output register.
    logic                out_valid_reg;
    logic [FREQ_W-1:0]   out_tone_reg;
    logic                out_sounding_reg;
    logic                out_melody_reg;
    logic                out_resume_reg;

    logic                in_accept;
    logic                a_move;
    logic                b_done;
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [NOTE_W-1:0]   ram_wr_data;
    logic [AW-1:0]       ram_rd_addr;
    logic [NOTE_W-1:0]   ram_rd_data;
    logic [COUNT_W-1:0]  a_step_next;
    logic [DUR_W-1:0]    elapsed_inc;
    logic [COUNT_W-1:0]  b_step_next;
    logic [FREQ_W-1:0]   note_freq;
    logic [DUR_W-1:0]    note_dur;

    // Handshake: the first stage empties only into an empty second stage,
    // so its read always sees the state left by the previous word.
    assign in_stall  = a_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign a_move    = a_valid_reg && !b_valid_reg;
    assign b_done    = b_valid_reg && (!out_valid_reg || !out_stall);

    // Input register of the first stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_move)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_op_reg    <= opcode_t'(opcode);
            a_start_reg <= start_address;
            a_count_reg <= note_count;
            a_prio_reg  <= alert_priority;
            a_freq_reg  <= note_frequency;
            a_dur_reg   <= note_duration;
        end
    end

    // Note address of the word in the first stage: the first note of a new
    // run, or for a tick the next note of the run or the saved melody note.
    assign a_step_next = run_step_reg + COUNT_W'(1);

    always_comb
    begin
        case (a_op_reg)
            OP_TICK:
            begin
                if (a_step_next < run_count_reg)
                begin
                    ram_rd_addr = wrap_addr(SUM_W'(run_start_reg) + SUM_W'(a_step_next));
                end
                else
                begin
                    ram_rd_addr = wrap_addr(SUM_W'(saved_start_reg) + SUM_W'(saved_step_reg));
                end
            end
            default:
            begin
                ram_rd_addr = wrap_addr(SUM_W'(a_start_reg));
            end
        endcase
    end

    assign ram_wr_en   = a_move && (a_op_reg == OP_WRITE);
    assign ram_wr_addr = wrap_addr(SUM_W'(a_start_reg));
    assign ram_wr_data = {a_freq_reg, a_dur_reg};

    mts_ram #(
        .WIDTH (NOTE_W),
        .DEPTH (NOTE_DEPTH)
    ) u_note_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (a_move),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Second stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (a_move)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (b_done)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            b_op_reg    <= a_op_reg;
            b_start_reg <= a_start_reg;
            b_count_reg <= a_count_reg;
            b_prio_reg  <= a_prio_reg;
        end
    end

    assign note_freq   = ram_rd_data[NOTE_W-1:DUR_W];
    assign note_dur    = ram_rd_data[DUR_W-1:0];
    assign elapsed_inc = (elapsed_reg == {DUR_W{1'b1}}) ? elapsed_reg
                                                        : elapsed_reg + DUR_W'(1);
    assign b_step_next = run_step_reg + COUNT_W'(1);

    // Run state update with the note read for this word.
    always_comb
    begin
        run_active_next      = run_active_reg;
        run_is_melody_next   = run_is_melody_reg;
        run_start_next       = run_start_reg;
        run_count_next       = run_count_reg;
        run_step_next        = run_step_reg;
        saved_valid_next     = saved_valid_reg;
        saved_start_next     = saved_start_reg;
        saved_count_next     = saved_count_reg;
        saved_step_next      = saved_step_reg;
        saved_remaining_next = saved_remaining_reg;
        elapsed_next         = elapsed_reg;
        duration_next        = duration_reg;
        held_prio_next       = held_prio_reg;
        tone_next            = tone_reg;
        if (b_done)
        begin
            case (b_op_reg)
                OP_MELODY:
                begin
                    // A melody with no notes is ignored.
                    if (b_count_reg != '0)
                    begin
                        run_start_next     = b_start_reg;
                        run_count_next     = b_count_reg;
                        run_step_next      = '0;
                        run_active_next    = 1'b1;
                        run_is_melody_next = 1'b1;
                        saved_valid_next   = 1'b0;
                        tone_next          = note_freq;
                        duration_next      = note_dur;
                        elapsed_next       = '0;
                    end
                end
                OP_ALERT:
                begin
                    // Refused only under a sounding alert of higher priority.
                    if (!(run_active_reg && !run_is_melody_reg && (held_prio_reg > b_prio_reg)))
                    begin
                        if (run_active_reg && run_is_melody_reg)
                        begin
                            saved_valid_next     = 1'b1;
                            saved_start_next     = run_start_reg;
                            saved_count_next     = run_count_reg;
                            saved_step_next      = run_step_reg;
                            saved_remaining_next = (elapsed_reg < duration_reg)
                                                   ? (duration_reg - elapsed_reg) : '0;
                        end
                        held_prio_next     = b_prio_reg;
                        run_start_next     = b_start_reg;
                        run_count_next     = b_count_reg;
                        run_step_next      = '0;
                        run_active_next    = 1'b1;
                        run_is_melody_next = 1'b0;
                        tone_next          = note_freq;
                        duration_next      = note_dur;
                        elapsed_next       = '0;
                    end
                end
                OP_TICK:
                begin
                    if (run_active_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= duration_reg)
                        begin
                            if (b_step_next < run_count_reg)
                            begin
                                // Advance to the next note of the run.
                                run_step_next = b_step_next;
                                tone_next     = note_freq;
                                duration_next = note_dur;
                                elapsed_next  = '0;
                            end
                            else if (saved_valid_reg)
                            begin
                                // Resume the interrupted melody.
                                run_start_next     = saved_start_reg;
                                run_count_next     = saved_count_reg;
                                run_step_next      = saved_step_reg;
                                saved_valid_next   = 1'b0;
                                run_is_melody_next = 1'b1;
                                tone_next          = note_freq;
                                duration_next      = saved_remaining_reg;
                                elapsed_next       = '0;
                            end
                            else
                            begin
                                // End of the run: fall silent.
                                tone_next          = '0;
                                run_active_next    = 1'b0;
                                run_is_melody_next = 1'b0;
                                run_step_next      = '0;
                                held_prio_next     = '0;
                            end
                        end
                    end
                end
                default:
                begin
                    // A note write leaves the run untouched.
                end
            endcase
        end
    end

    // Run state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg      <= 1'b0;
            run_is_melody_reg   <= 1'b0;
            run_start_reg       <= '0;
            run_count_reg       <= '0;
            run_step_reg        <= '0;
            saved_valid_reg     <= 1'b0;
            saved_start_reg     <= '0;
            saved_count_reg     <= '0;
            saved_step_reg      <= '0;
            saved_remaining_reg <= '0;
            elapsed_reg         <= '0;
            duration_reg        <= '0;
            held_prio_reg       <= '0;
            tone_reg            <= '0;
        end
        else
        begin
            run_active_reg      <= run_active_next;
            run_is_melody_reg   <= run_is_melody_next;
            run_start_reg       <= run_start_next;
            run_count_reg       <= run_count_next;
            run_step_reg        <= run_step_next;
            saved_valid_reg     <= saved_valid_next;
            saved_start_reg     <= saved_start_next;
            saved_count_reg     <= saved_count_next;
            saved_step_reg      <= saved_step_next;
            saved_remaining_reg <= saved_remaining_next;
            elapsed_reg         <= elapsed_next;
            duration_reg        <= duration_next;
            held_prio_reg       <= held_prio_next;
            tone_reg            <= tone_next;
        end
    end

    // Output register, loaded with the buzzer state after each word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (b_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_done)
        begin
            out_tone_reg     <= tone_next;
            out_sounding_reg <= run_active_next;
            out_melody_reg   <= run_active_next && run_is_melody_next;
            out_resume_reg   <= saved_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign tone_frequency = out_tone_reg;
    assign sounding       = out_sounding_reg;
    assign melody_mode    = out_melody_reg;
    assign resume_pending = out_resume_reg;

    // An idle sequencer always holds the low priority.
    a_idle_prio_low : assert property (@(posedge clk) disable iff (!rst_n)
        !run_active_reg |-> (held_prio_reg == '0))
        else $error("priority held while no run is active");

    // A saved melody exists only under a sounding alert.
    a_saved_under_alert : assert property (@(posedge clk) disable iff (!rst_n)
        saved_valid_reg |-> (run_active_reg && !run_is_melody_reg))
        else $error("saved melody without an active alert");

    // A delivered result never shows melody mode without a run.
    a_melody_sounding : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_melody_reg || out_sounding_reg))
        else $error("melody mode reported while silent");

    // The memory is read only once the state of the prior word is final.
    a_read_after_update : assert property (@(posedge clk) disable iff (!rst_n)
        b_done |=> !b_valid_reg || $past(a_move))
        else $error("second stage refilled without a memory read");

endmodule : melody_tone_sequencer
`default_nettype wire

>>> rtl/mts_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mts_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled.
// ----------------------------------------------------------------------------
module mts_ram
    import mts_pkg::*;
#(
    parameter int WIDTH = NOTE_W,
    parameter int DEPTH = NOTE_DEPTH_DEFAULT
)
(
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : mts_ram
`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Melody tone sequencer testbench
// Drives command words into the sequencer and checks every result word against
// a cycle-free model of the note memory and the run, save and resume state.
// A short table of directed words comes first. It is followed by random words
// that never play a note entry that has not been written. Both sides of the
// block idle and stall at random.
// ----------------------------------------------------------------------------
module testbench
    import mts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 400;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_LIMIT  = 2000;

    // One command word as offered to the block.
    typedef struct {
        opcode_t             op;
        logic [START_W-1:0]  addr;
        logic [COUNT_W-1:0]  count;
        logic [PRIO_W-1:0]   prio;
        logic [FREQ_W-1:0]   freq;
        logic [DUR_W-1:0]    dur;
    } seq_word_t;

    // One result word: buzzer frequency and status bits.
    typedef struct {
        logic [FREQ_W-1:0] tone;
        logic              snd;
        logic              mel;
        logic              pend;
    } buzzer_out_t;

    // Directed row: a word and, where it is obvious, its literal result.
    typedef struct {
        seq_word_t   word;
        bit          literal;
        buzzer_out_t want;
    } dir_row_t;

    // Run, save and resume state of the sequencer.
    typedef struct {
        bit                 active;
        bit                 is_mel;
        bit [START_W-1:0]   rstart;
        bit [COUNT_W-1:0]   rcount;
        bit [COUNT_W-1:0]   rstep;
        bit                 sv;
        bit [START_W-1:0]   sstart;
        bit [COUNT_W-1:0]   scount;
        bit [COUNT_W-1:0]   sstep;
        bit [DUR_W-1:0]     srem;
        bit [DUR_W-1:0]     elapsed;
        bit [DUR_W-1:0]     cur_dur;
        bit [PRIO_W-1:0]    prio;
        bit [FREQ_W-1:0]    tone;
        bit                 miss;
        bit [START_W-1:0]   miss_addr;
    } seq_state_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OPCODE_W-1:0] opcode = '0;
    logic [START_W-1:0]  start_address = '0;
    logic [COUNT_W-1:0]  note_count = '0;
    logic [PRIO_W-1:0]   alert_priority = '0;
    logic [FREQ_W-1:0]   note_frequency = '0;
    logic [DUR_W-1:0]    note_duration = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [FREQ_W-1:0]   tone_frequency;
    logic                sounding;
    logic                melody_mode;
    logic                resume_pending;

    // Model of the note memory and the sequencer state.
    bit [NOTE_W-1:0]     note_mem [NOTE_DEPTH_DEFAULT];
    bit                  note_written [NOTE_DEPTH_DEFAULT];
    logic [START_W-1:0]  written_list [$];
    seq_state_t          seq_now;
    buzzer_out_t         expected_buzzer [$];
    dir_row_t            dir_rows [$];

    int burst_left;
    int mismatches;
    int results_checked;
    int melody_starts;
    int alerts_taken;
    int alerts_refused;
    int melody_resumes;
    int filler_writes;

    melody_tone_sequencer u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .start_address  (start_address),
        .note_count     (note_count),
        .alert_priority (alert_priority),
        .note_frequency (note_frequency),
        .note_duration  (note_duration),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tone_frequency (tone_frequency),
        .sounding       (sounding),
        .melody_mode    (melody_mode),
        .resume_pending (resume_pending)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Starts note number step of the run held in s; flags an unwritten entry.
    function automatic seq_state_t sound_note(seq_state_t s, bit [COUNT_W-1:0] step);
        bit [START_W-1:0] a;
        a = s.rstart + step[START_W-1:0];
        if (!note_written[a])
        begin
            s.miss      = 1'b1;
            s.miss_addr = a;
        end
        s.tone    = note_mem[a][NOTE_W-1:DUR_W];
        s.cur_dur = note_mem[a][DUR_W-1:0];
        s.elapsed = '0;
        return s;
    endfunction

    // Sequencer state after one word; note writes are committed by the caller.
    function automatic seq_state_t next_sequencer_state(seq_state_t s, seq_word_t w);
        seq_state_t n;
        n      = s;
        n.miss = 1'b0;
        case (w.op)
            OP_MELODY:
            begin
                if (w.count != 0)
                begin
                    n.rstart = w.addr;
                    n.rcount = w.count;
                    n.rstep  = '0;
                    n.active = 1'b1;
                    n.is_mel = 1'b1;
                    n.sv     = 1'b0;
                    n        = sound_note(n, '0);
                end
            end
            OP_ALERT:
            begin
                // A higher-priority alert that is sounding keeps the buzzer.
                if (!(s.active && !s.is_mel && s.prio > w.prio))
                begin
                    if (s.active && s.is_mel)
                    begin
                        n.sv     = 1'b1;
                        n.sstart = s.rstart;
                        n.scount = s.rcount;
                        n.sstep  = s.rstep;
                        n.srem   = (s.elapsed < s.cur_dur) ? s.cur_dur - s.elapsed : '0;
                    end
                    n.prio   = w.prio;
                    n.rstart = w.addr;
                    n.rcount = w.count;
                    n.rstep  = '0;
                    n.active = 1'b1;
                    n.is_mel = 1'b0;
                    n        = sound_note(n, '0);
                end
            end
            OP_TICK:
            begin
                if (s.active)
                begin
                    if (n.elapsed != '1)
                        n.elapsed = n.elapsed + 1'b1;
                    if (n.elapsed >= n.cur_dur)
                    begin
                        n.rstep = n.rstep + 1'b1;
                        if (n.rstep < n.rcount)
                        begin
                            n = sound_note(n, n.rstep);
                        end
                        else if (n.sv)
                        begin
                            // End of an alert: pick the interrupted melody back up.
                            n.rstart  = n.sstart;
                            n.rcount  = n.scount;
                            n.rstep   = n.sstep;
                            n.sv      = 1'b0;
                            n         = sound_note(n, n.rstep);
                            n.cur_dur = n.srem;
                            n.is_mel  = 1'b1;
                        end
                        else
                        begin
                            n.tone   = '0;
                            n.active = 1'b0;
                            n.is_mel = 1'b0;
                            n.rstep  = '0;
                            n.prio   = '0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return n;
    endfunction

    // Note durations are mostly short so that runs finish within a few ticks.
    function automatic logic [DUR_W-1:0] note_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return DUR_W'($urandom_range(0, 3));
        else if (r < 95)
            return DUR_W'($urandom_range(4, 24));
        return DUR_W'($urandom_range(0, 65535));
    endfunction

    task automatic add_row(input opcode_t op, input int addr, input int count, input int prio,
                           input int freq, input int dur, input bit literal,
                           input int tone, input bit snd, input bit mel, input bit pend);
        dir_row_t row;
        row.word.op    = op;
        row.word.addr  = START_W'(addr);
        row.word.count = COUNT_W'(count);
        row.word.prio  = PRIO_W'(prio);
        row.word.freq  = FREQ_W'(freq);
        row.word.dur   = DUR_W'(dur);
        row.literal    = literal;
        row.want.tone  = FREQ_W'(tone);
        row.want.snd   = snd;
        row.want.mel   = mel;
        row.want.pend  = pend;
        dir_rows.push_back(row);
    endtask

    // Offers one word in bursts with random gaps, waits for it to be taken,
    // then advances the model and queues the expected result.
    task automatic send_word(input seq_word_t w, input bit literal, input buzzer_out_t want);
        int gap;
        seq_state_t prev;
        buzzer_out_t got;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid       <= 1'b1;
        opcode         <= w.op;
        start_address  <= w.addr;
        note_count     <= w.count;
        alert_priority <= w.prio;
        note_frequency <= w.freq;
        note_duration  <= w.dur;
        do
            @(posedge clk);
        while (in_stall);

        prev    = seq_now;
        seq_now = next_sequencer_state(seq_now, w);
        if (w.op == OP_WRITE)
        begin
            note_mem[w.addr] = {w.freq, w.dur};
            if (!note_written[w.addr])
                written_list.push_back(w.addr);
            note_written[w.addr] = 1'b1;
        end
        if (w.op == OP_MELODY && w.count != 0)
            melody_starts++;
        if (w.op == OP_ALERT)
        begin
            if (prev.active && !prev.is_mel && prev.prio > w.prio)
                alerts_refused++;
            else
                alerts_taken++;
        end
        if (w.op == OP_TICK && prev.sv && !seq_now.sv)
            melody_resumes++;

        got.tone = seq_now.tone;
        got.snd  = seq_now.active;
        got.mel  = seq_now.active && seq_now.is_mel;
        got.pend = seq_now.sv;
        expected_buzzer.push_back(literal ? want : got);
    endtask

    // Receiver: stretches of free flow and random stalls, with one long hold.
    initial
    begin : receiver
        int seg;
        int len;
        int mode;
        seg = 0;
        wait (rst_n);
        forever
        begin
            seg++;
            if (seg == 6)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 2);
                len  = $urandom_range(10, 60);
                repeat (len)
                begin
                    if (mode == 0)
                        out_stall <= 1'b0;
                    else if (mode == 1)
                        out_stall <= ($urandom_range(0, 3) == 0);
                    else
                        out_stall <= ($urandom_range(0, 1) == 0);
                    @(posedge clk);
                end
            end
        end
    end

    // Result checker: every taken word is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        buzzer_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (expected_buzzer.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: tone %h sounding %b melody %b pending %b",
                             tone_frequency, sounding, melody_mode, resume_pending);
            end
            else
            begin
                want = expected_buzzer.pop_front();
                if (tone_frequency !== want.tone || sounding !== want.snd ||
                    melody_mode !== want.mel || resume_pending !== want.pend)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("word %0d mismatch: expected tone %h snd %b mel %b pend %b",
                                 results_checked, want.tone, want.snd, want.mel, want.pend);
                        $display("    got tone %h snd %b mel %b pend %b",
                                 tone_frequency, sounding, melody_mode, resume_pending);
                    end
                end
            end
        end
    end

    // Run limit, far above the slowest legal run.
    initial
    begin : watchdog
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_buzzer.size());
        $display("melody_tone_sequencer regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        seq_word_t   w;
        seq_state_t  probe;
        buzzer_out_t none;
        int          random_words;
        int          r;
        int          drain;

        none         = '{default: '0};
        seq_now      = '{default: '0};
        burst_left   = 0;
        random_words = 0;

        // Directed words: memory writes at the extremes, wrapping melody,
        // count-zero alert, refusal, equal priority, save and resume, a
        // remaining time floored at zero, and a melody under a held priority.
        add_row(OP_TICK,     0,   0, 0, 16'h0000, 16'h0000, 1, 0, 0, 0, 0);
        add_row(OP_MELODY,   0,   0, 0, 16'h0000, 16'h0000, 1, 0, 0, 0, 0);
        add_row(OP_WRITE,    0,   0, 0, 16'hFFFF, 16'h0002, 1, 0, 0, 0, 0);
        add_row(OP_WRITE,  255, 511, 3, 16'h0000, 16'h0000, 1, 0, 0, 0, 0);
        add_row(OP_WRITE,    1,   0, 0, 16'h1234, 16'hFFFF, 1, 0, 0, 0, 0);
        add_row(OP_WRITE,    2,   0, 0, 16'h8001, 16'h0001, 1, 0, 0, 0, 0);
        add_row(OP_MELODY, 255,   3, 0, 16'h0000, 16'h0000, 1, 0, 1, 1, 0);
        add_row(OP_TICK,     0,   0, 0, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
        add_row(OP_TICK,   255, 511, 3, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0);
        add_row(OP_ALERT,    2,   0, 2, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
        add_row(OP_ALERT,    0,   1, 1, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
        add_row(OP_ALERT,    0,   1, 3, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
        add_row(OP_ALERT,    2,   1, 3, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
        add_row(OP_TICK,     0,   0, 0, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
        add_row(OP_TICK,     0,   0, 0, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
        add_row(OP_TICK,     0,   0, 0, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
        add_row(OP_ALERT,    1, 256, 0, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
        add_row(OP_MELODY, 255,   1, 0, 16'h0000, 16'h0000, 1, 0, 1, 1, 0);
        add_row(OP_ALERT,    2,   1, 1, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
        add_row(OP_TICK,     0,   0, 0, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
        add_row(OP_TICK,     0,   0, 0, 16'h0000, 16'h0000, 1, 0, 0, 0, 0);
        add_row(OP_ALERT,    0,   2, 3, 16'h0000, 16'h0000, 1, 16'hFFFF, 1, 0, 0);
        add_row(OP_MELODY,   2,   1, 0, 16'h0000, 16'h0000, 1, 16'h8001, 1, 1, 0);
        add_row(OP_ALERT,  255,   1, 1, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
        add_row(OP_TICK,     0,   0, 0, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);

        // Apply reset once, then release it.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].literal, dir_rows[i].want);

        // Random words. Runs mostly start on written notes; any word that
        // would play an unwritten entry becomes a write of that entry.
        while (random_words < RANDOM_WORDS)
        begin
            r       = $urandom_range(0, 99);
            w.addr  = START_W'($urandom_range(0, 255));
            w.prio  = PRIO_W'($urandom_range(0, 3));
            w.freq  = ($urandom_range(0, 9) == 0) ? '0 : FREQ_W'($urandom_range(0, 65535));
            w.dur   = note_length();
            if (r < 25)
                w.op = OP_WRITE;
            else if (r < 35)
                w.op = OP_MELODY;
            else if (r < 45)
                w.op = OP_ALERT;
            else
                w.op = OP_TICK;
            if ((w.op == OP_MELODY || w.op == OP_ALERT) && written_list.size() != 0 &&
                $urandom_range(0, 9) < 6)
                w.addr = written_list[$urandom_range(0, written_list.size() - 1)];
            r = $urandom_range(0, 99);
            if (r < 60)
                w.count = COUNT_W'($urandom_range(0, 4));
            else if (r < 90)
                w.count = COUNT_W'($urandom_range(5, 24));
            else if (r < 94)
                w.count = COUNT_W'(256);
            else
                w.count = COUNT_W'($urandom_range(25, 256));

            probe = next_sequencer_state(seq_now, w);
            if (probe.miss)
            begin
                w.op   = OP_WRITE;
                w.addr = probe.miss_addr;
                w.dur  = note_length();
                filler_writes++;
            end
            send_word(w, 1'b0, none);
            random_words++;
        end
        in_valid <= 1'b0;

        // Let the pipeline drain, then let the clock run on idle.
        drain = 0;
        while (expected_buzzer.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);

        if (expected_buzzer.size() != 0)
        begin
            mismatches += expected_buzzer.size();
            $display("%0d expected result words never arrived", expected_buzzer.size());
        end
        $display("checked %0d result words from %0d directed and %0d random command words",
                 results_checked, dir_rows.size(), random_words);
        $display("runs: %0d melodies, %0d alerts taken, %0d refused, %0d resumes, %0d fill writes",
                 melody_starts, alerts_taken, alerts_refused, melody_resumes, filler_writes);
        if (mismatches == 0)
            $display("melody_tone_sequencer regression: pass");
        else
            $display("melody_tone_sequencer regression: fail");
        $finish;
    end

endmodule
